@@ src/spe_pkg.sv @@
package spe_pkg;

    // Default sizes
    localparam int MAX_TERMS_DEF = 64;
    localparam int COEF_BITS_DEF = 32;
    localparam int EXP_BITS_DEF  = 16;

    // Item kinds
    localparam logic [2:0] KIND_LOAD     = 3'd0;
    localparam logic [2:0] KIND_ADD_TERM = 3'd1;
    localparam logic [2:0] KIND_ADD      = 3'd2;
    localparam logic [2:0] KIND_SUB      = 3'd3;
    localparam logic [2:0] KIND_MUL      = 3'd4;
    localparam logic [2:0] KIND_READ     = 3'd5;
    localparam logic [2:0] KIND_CLR_ACC  = 3'd6;
    localparam logic [2:0] KIND_CLR_OPND = 3'd7;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_WRAP  = 2'd3;

    // Table select, upper address bits of the term memory
    localparam logic [1:0] TBL_ACC  = 2'd0;
    localparam logic [1:0] TBL_OPND = 2'd1;
    localparam logic [1:0] TBL_SCR  = 2'd2;

endpackage

@@ src/sparse_polynomial_engine.sv @@
// Channel  | Handshake           | Beat fields
// ---------+---------------------+----------------------------------------------------
// input    | in_valid, in_stall  | kind, coefficient, exponent, term_index
// output   | out_valid, out_stall| status, read_coefficient, read_exponent, term_count
//
// One item at a time; the input is taken only while the engine is idle, even while a
// result beat still waits. All terms sit in one term memory with one read port and one
// write port (registered read).
// A merge scans the target table entry by entry: read (S_SRCH), then compare (S_CMP).
// Add/subtract: each operand term is merged into the accumulator. Multiply: per term pair
// a shift-add and a scratch scan, then the scratch table is copied into the accumulator.
// Reset clears the counts, state and output valid; term memory needs no clearing.
module sparse_polynomial_engine #(
    parameter int MAX_TERMS = spe_pkg::MAX_TERMS_DEF,
    parameter int COEF_BITS = spe_pkg::COEF_BITS_DEF,
    parameter int EXP_BITS  = spe_pkg::EXP_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic signed [31:0] coefficient,
    input  logic signed [15:0] exponent,
    input  logic [5:0]         term_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] read_coefficient,
    output logic signed [15:0] read_exponent,
    output logic [6:0]         term_count
);

    localparam int IDX_W  = $clog2(MAX_TERMS);
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
    localparam int ADDR_W = IDX_W + 2;
    localparam int WORD_W = COEF_BITS + EXP_BITS;
    localparam int MCNT_W = $clog2(COEF_BITS + 1);
    localparam int DEPTH  = 4 * MAX_TERMS;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_ACC_RD   = 14'b00000000000010,
        S_ACC_GET  = 14'b00000000000100,
        S_OPND_RD  = 14'b00000000001000,
        S_OPND_GET = 14'b00000000010000,
        S_MUL      = 14'b00000000100000,
        S_SRCH     = 14'b00000001000000,
        S_CMP      = 14'b00000010000000,
        S_NEXT     = 14'b00000100000000,
        S_COPY_RD  = 14'b00001000000000,
        S_COPY_WR  = 14'b00010000000000,
        S_READ_RD  = 14'b00100000000000,
        S_READ_GET = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]           kind_reg;
    logic [COEF_BITS-1:0] term_c_reg;
    logic [EXP_BITS-1:0]  term_e_reg;
    logic [1:0]           tgt_reg;
    logic [CNT_W-1:0]     k_reg, i_reg, j_reg;
    logic [CNT_W-1:0]     acc_cnt_reg, opnd_cnt_reg, scr_cnt_reg;
    logic [COEF_BITS-1:0] a_c_reg;
    logic [EXP_BITS-1:0]  a_e_reg;
    logic [COEF_BITS-1:0] mul_a_reg, mul_b_reg, prod_reg;
    logic [MCNT_W-1:0]    mcnt_reg;
    logic                 drop_reg, wrap_reg, range_bad_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [COEF_BITS-1:0] res_c_reg;
    logic [EXP_BITS-1:0]  res_e_reg;
    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic signed [31:0]   rc_out_reg;
    logic signed [15:0]   re_out_reg;
    logic [6:0]           cnt_out_reg;

    logic [WORD_W-1:0]    mem [0:DEPTH-1];
    logic [WORD_W-1:0]    rd_data_reg;
    logic [ADDR_W-1:0]    mem_raddr, mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic                 mem_we;

    logic signed [63:0]   coef_sx;
    logic signed [31:0]   exp_sx;
    logic [COEF_BITS-1:0] coef_in, rd_c;
    logic [EXP_BITS-1:0]  exp_in, rd_e;
    logic [CMP_W-1:0]     idx_ext, acc_ext;
    logic                 idx_ok, accept, out_free, match, tgt_full, at_end;
    logic [CNT_W-1:0]     tgt_cnt, j_inc, i_inc;
    logic [EXP_BITS:0]    esum;
    logic signed [63:0]   rc_sx;
    logic signed [31:0]   re_sx;

    // Fit input fields to the internal widths
    assign coef_sx = 64'(coefficient);
    assign exp_sx  = 32'(exponent);
    assign coef_in = coef_sx[COEF_BITS-1:0];
    assign exp_in  = exp_sx[EXP_BITS-1:0];
    assign idx_ext = CMP_W'(term_index);
    assign acc_ext = CMP_W'(acc_cnt_reg);
    assign idx_ok  = idx_ext < acc_ext;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign rd_c  = rd_data_reg[WORD_W-1:EXP_BITS];
    assign rd_e  = rd_data_reg[EXP_BITS-1:0];
    assign match = (rd_e == term_e_reg);
    assign j_inc = j_reg + CNT_W'(1);
    assign i_inc = i_reg + CNT_W'(1);
    assign esum  = {a_e_reg[EXP_BITS-1], a_e_reg} + {rd_e[EXP_BITS-1], rd_e};

    // Pick the count of the table being merged into
    always_comb
    begin
        case (tgt_reg)
            spe_pkg::TBL_ACC:  tgt_cnt = acc_cnt_reg;
            spe_pkg::TBL_OPND: tgt_cnt = opnd_cnt_reg;
            default:           tgt_cnt = scr_cnt_reg;
        endcase
    end
    assign at_end   = (k_reg >= tgt_cnt);
    assign tgt_full = (tgt_cnt >= CNT_W'(MAX_TERMS));

    // Sequence the item
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (kind)
                        spe_pkg::KIND_LOAD, spe_pkg::KIND_ADD_TERM:
                            state_next = S_SRCH;
                        spe_pkg::KIND_ADD, spe_pkg::KIND_SUB:
                            state_next = (opnd_cnt_reg == '0) ? S_DONE : S_OPND_RD;
                        spe_pkg::KIND_MUL:
                            state_next = (acc_cnt_reg == '0 || opnd_cnt_reg == '0)
                                         ? S_COPY_RD : S_ACC_RD;
                        spe_pkg::KIND_READ:
                            state_next = idx_ok ? S_READ_RD : S_DONE;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_ACC_RD:   state_next = S_ACC_GET;
            S_ACC_GET:  state_next = S_OPND_RD;
            S_OPND_RD:  state_next = S_OPND_GET;
            S_OPND_GET: state_next = (kind_reg == spe_pkg::KIND_MUL) ? S_MUL : S_SRCH;
            S_MUL:      state_next = (mcnt_reg == MCNT_W'(COEF_BITS)) ? S_SRCH : S_MUL;
            S_SRCH:     state_next = at_end ? S_NEXT : S_CMP;
            S_CMP:      state_next = match ? S_NEXT : S_SRCH;
            S_NEXT:
            begin
                if (kind_reg inside {spe_pkg::KIND_ADD, spe_pkg::KIND_SUB})
                    state_next = (j_inc < opnd_cnt_reg) ? S_OPND_RD : S_DONE;
                else if (kind_reg == spe_pkg::KIND_MUL)
                begin
                    if (j_inc < opnd_cnt_reg)
                        state_next = S_OPND_RD;
                    else
                        state_next = (i_inc < acc_cnt_reg) ? S_ACC_RD : S_COPY_RD;
                end
                else
                    state_next = S_DONE;
            end
            S_COPY_RD:  state_next = (k_reg < scr_cnt_reg) ? S_COPY_WR : S_DONE;
            S_COPY_WR:  state_next = S_COPY_RD;
            S_READ_RD:  state_next = S_READ_GET;
            S_READ_GET: state_next = S_DONE;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Drive the memory read address
    always_comb
    begin
        case (state_reg)
            S_ACC_RD:  mem_raddr = {spe_pkg::TBL_ACC, i_reg[IDX_W-1:0]};
            S_OPND_RD: mem_raddr = {spe_pkg::TBL_OPND, j_reg[IDX_W-1:0]};
            S_SRCH:    mem_raddr = {tgt_reg, k_reg[IDX_W-1:0]};
            S_COPY_RD: mem_raddr = {spe_pkg::TBL_SCR, k_reg[IDX_W-1:0]};
            S_READ_RD: mem_raddr = {spe_pkg::TBL_ACC, idx_reg};
            default:   mem_raddr = '0;
        endcase
    end

    // Drive the memory write: append, accumulate or copy
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        case (state_reg)
            S_SRCH:
            begin
                mem_we    = at_end && !tgt_full;
                mem_waddr = {tgt_reg, tgt_cnt[IDX_W-1:0]};
                mem_wdata = {term_c_reg, term_e_reg};
            end
            S_CMP:
            begin
                mem_we    = match;
                mem_waddr = {tgt_reg, k_reg[IDX_W-1:0]};
                mem_wdata = {rd_c + term_c_reg, rd_e};
            end
            S_COPY_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {spe_pkg::TBL_ACC, k_reg[IDX_W-1:0]};
                mem_wdata = rd_data_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Term memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // Control state, counts and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_cnt_reg   <= '0;
            opnd_cnt_reg  <= '0;
            scr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (kind == spe_pkg::KIND_CLR_ACC)
                    acc_cnt_reg <= '0;
                if (kind == spe_pkg::KIND_CLR_OPND)
                    opnd_cnt_reg <= '0;
                if (kind == spe_pkg::KIND_MUL)
                    scr_cnt_reg <= '0;
            end
            if (state_reg == S_SRCH && at_end && !tgt_full)
            begin
                case (tgt_reg)
                    spe_pkg::TBL_ACC:  acc_cnt_reg  <= acc_cnt_reg + CNT_W'(1);
                    spe_pkg::TBL_OPND: opnd_cnt_reg <= opnd_cnt_reg + CNT_W'(1);
                    default:           scr_cnt_reg  <= scr_cnt_reg + CNT_W'(1);
                endcase
            end
            if (state_reg == S_COPY_RD && k_reg >= scr_cnt_reg)
                acc_cnt_reg <= scr_cnt_reg;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_reg      <= kind;
                    term_c_reg    <= coef_in;
                    term_e_reg    <= exp_in;
                    tgt_reg       <= (kind == spe_pkg::KIND_LOAD) ? spe_pkg::TBL_OPND
                                                                  : spe_pkg::TBL_ACC;
                    k_reg         <= '0;
                    i_reg         <= '0;
                    j_reg         <= '0;
                    drop_reg      <= 1'b0;
                    wrap_reg      <= 1'b0;
                    range_bad_reg <= (kind == spe_pkg::KIND_READ) && !idx_ok;
                    idx_reg       <= idx_ext[IDX_W-1:0];
                    res_c_reg     <= '0;
                    res_e_reg     <= '0;
                end
            end
            S_ACC_GET:
            begin
                a_c_reg <= rd_c;
                a_e_reg <= rd_e;
            end
            S_OPND_GET:
            begin
                k_reg <= '0;
                if (kind_reg == spe_pkg::KIND_MUL)
                begin
                    mul_a_reg  <= a_c_reg;
                    mul_b_reg  <= rd_c;
                    prod_reg   <= '0;
                    mcnt_reg   <= '0;
                    term_e_reg <= esum[EXP_BITS-1:0];
                    tgt_reg    <= spe_pkg::TBL_SCR;
                    if (esum[EXP_BITS] != esum[EXP_BITS-1])
                        wrap_reg <= 1'b1;
                end
                else
                begin
                    term_c_reg <= (kind_reg == spe_pkg::KIND_SUB) ? (COEF_BITS'(0) - rd_c)
                                                                  : rd_c;
                    term_e_reg <= rd_e;
                    tgt_reg    <= spe_pkg::TBL_ACC;
                end
            end
            S_MUL:
            begin
                // Shift-add one multiplier bit per cycle
                if (mcnt_reg == MCNT_W'(COEF_BITS))
                    term_c_reg <= prod_reg;
                else
                begin
                    if (mul_b_reg[0])
                        prod_reg <= prod_reg + mul_a_reg;
                    mul_a_reg <= mul_a_reg << 1;
                    mul_b_reg <= mul_b_reg >> 1;
                    mcnt_reg  <= mcnt_reg + MCNT_W'(1);
                end
            end
            S_SRCH:
            begin
                if (at_end && tgt_full)
                    drop_reg <= 1'b1;
            end
            S_CMP:
            begin
                if (!match)
                    k_reg <= k_reg + CNT_W'(1);
            end
            S_NEXT:
            begin
                k_reg <= '0;
                if (kind_reg == spe_pkg::KIND_MUL && !(j_inc < opnd_cnt_reg))
                begin
                    j_reg <= '0;
                    i_reg <= i_inc;
                end
                else
                    j_reg <= j_inc;
            end
            S_COPY_WR:
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            S_READ_GET:
            begin
                res_c_reg <= rd_c;
                res_e_reg <= rd_e;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (range_bad_reg)
                        status_reg <= spe_pkg::ST_RANGE;
                    else if (drop_reg)
                        status_reg <= spe_pkg::ST_FULL;
                    else if (wrap_reg)
                        status_reg <= spe_pkg::ST_WRAP;
                    else
                        status_reg <= spe_pkg::ST_OK;
                    rc_out_reg  <= rc_sx[31:0];
                    re_out_reg  <= re_sx[15:0];
                    cnt_out_reg <= acc_ext[6:0];
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    // Sign-extend read fields to the port widths
    assign rc_sx = 64'(signed'(res_c_reg));
    assign re_sx = 32'(signed'(res_e_reg));

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign read_coefficient = rc_out_reg;
    assign read_exponent    = re_out_reg;
    assign term_count       = cnt_out_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_cnt_reg <= CNT_W'(MAX_TERMS) && opnd_cnt_reg <= CNT_W'(MAX_TERMS))
        else $error("term count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside completion");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == spe_pkg::ST_RANGE
        |-> rc_out_reg == '0 && re_out_reg == '0)
        else $error("out of range read returned data");

endmodule
